// File: src/irc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_pkg
// shared types and codes for the interval region classifier
// ----------------------------------------------------------------------------
package irc_pkg;

    localparam int COORD_W   = 31;
    localparam int SHIFT_W   = 32;
    localparam int SLOT_W    = 6;
    localparam int USED_W    = 7;
    localparam int RC_W      = 7;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_PLACE = 2'd2,
        OP_END   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOMATCH = 2'd1,
        STAT_SLOT    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_BEGIN,
        S_SCAN,
        S_UPDATE,
        S_TALLY,
        S_REPLY
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] r_begin;
        logic [COORD_W-1:0] r_end;
        logic               rep;
    } region_t;

    typedef struct packed {
        status_t                    status;
        logic [SLOT_W-1:0]          matched_region;
        logic                       repeat_match;
        logic                       first_in_region;
        logic                       repeat_heavy;
        logic signed [SHIFT_W-1:0]  shifted_start;
        logic signed [SHIFT_W-1:0]  shifted_end;
        logic [USED_W-1:0]          regions_used;
    } res_t;

endpackage

// File: src/irc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc channel interfaces
// valid/ready channels for operations and results
// ----------------------------------------------------------------------------
interface irc_in_if;
    import irc_pkg::*;

    logic                 valid;
    logic                 ready;
    op_t                  opcode;
    logic [SLOT_W-1:0]    slot;
    logic [COORD_W-1:0]   coord_a;
    logic [COORD_W-1:0]   coord_b;
    logic                 repeat_region;

    modport source (output valid, opcode, slot, coord_a, coord_b, repeat_region,
                    input ready);
    modport sink   (input valid, opcode, slot, coord_a, coord_b, repeat_region,
                    output ready);
endinterface

interface irc_out_if;
    import irc_pkg::*;

    logic                       valid;
    logic                       ready;
    status_t                    status;
    logic [SLOT_W-1:0]          matched_region;
    logic                       repeat_match;
    logic                       first_in_region;
    logic                       repeat_heavy;
    logic signed [SHIFT_W-1:0]  shifted_start;
    logic signed [SHIFT_W-1:0]  shifted_end;
    logic [USED_W-1:0]          regions_used;

    modport source (output valid, status, matched_region, repeat_match, first_in_region,
                           repeat_heavy, shifted_start, shifted_end, regions_used,
                    input ready);
    modport sink   (input valid, status, matched_region, repeat_match, first_in_region,
                          repeat_heavy, shifted_start, shifted_end, regions_used,
                    output ready);
endinterface

// File: src/interval_region_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_region_classifier
// region table with first-match interval placement, hit tallies and shifts
// ----------------------------------------------------------------------------
// channel   dir  handshake      payload
// items     in   valid/ready    opcode, slot, coord_a, coord_b, repeat_region
// results   out  valid/ready    status, matched_region, repeat_match, ...
// cfg       in   cfg_we         cfg_index, cfg_wdata
//
// one operation at a time, n active regions; load writes one table entry, begin pass
// clears the n tallies (the n move entries in move mode), end of pass counts the
// entries with a nonzero tally, place tests entries in order and updates the first match
// the scan reads one region table entry per cycle
// reset starts a sweep over all MAX_REGIONS entries that zeroes the tally and
// move tables; items are held off until it ends
// a stalled result sits in the output register; the following operation is
// accepted and runs, then holds in reply until the register drains
// ----------------------------------------------------------------------------
module interval_region_classifier #(
    parameter int MAX_REGIONS    = 64,
    parameter int HIT_COUNT_BITS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    irc_in_if.sink                        items,
    irc_out_if.source                     results,
    input  logic                          cfg_we,
    input  logic [irc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [irc_pkg::CFG_W-1:0]     cfg_wdata
);
    import irc_pkg::*;

    localparam int IDX_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
    localparam int HIT_W  = 2 * HIT_COUNT_BITS;
    localparam int MOVE_W = COORD_W + 1;

    region_t           region_mem [MAX_REGIONS];
    logic [HIT_W-1:0]  hit_mem    [MAX_REGIONS];
    logic [MOVE_W-1:0] move_mem   [MAX_REGIONS];

    region_t           region_rdata;
    logic [HIT_W-1:0]  hit_rdata;
    logic [MOVE_W-1:0] move_rdata;

    logic              region_we;
    logic [IDX_W-1:0]  region_waddr;
    region_t           region_wdata;
    logic              region_re;

    logic              hit_we;
    logic [IDX_W-1:0]  hit_waddr;
    logic [HIT_W-1:0]  hit_wdata;
    logic              hit_re;
    logic [IDX_W-1:0]  hit_raddr;

    logic              move_we;
    logic [IDX_W-1:0]  move_waddr;
    logic [MOVE_W-1:0] move_wdata;
    logic              move_re;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic               rpt_reg, rpt_next;
    logic [COORD_W-1:0] lo_reg, lo_next;
    logic [COORD_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    res_t               res_reg, res_next;
    res_t               out_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    logic               move_mode_reg;
    logic [RC_W-1:0]    region_count_reg;

    logic [CNT_W-1:0]          n_active;
    logic                      scan_more;
    logic                      scan_done;
    logic                      out_free;
    logic                      accept;
    logic                      slot_ok;
    logic                      last_clear;
    logic                      match;
    logic [HIT_COUNT_BITS-1:0] rep_cnt;
    logic [HIT_COUNT_BITS-1:0] uni_cnt;
    logic                      started;
    logic [COORD_W-1:0]        base_low;

    always_comb
    begin
        if (32'(region_count_reg) > MAX_REGIONS)
        begin
            n_active = CNT_W'(MAX_REGIONS);
        end
        else
        begin
            n_active = CNT_W'(region_count_reg);
        end
    end

    assign scan_more  = scan_idx_reg < n_active;
    assign scan_done  = !chk_valid_reg && !scan_more;
    assign out_free   = !out_valid_reg || results.ready;
    assign accept     = items.valid && items.ready;
    assign slot_ok    = 32'(items.slot) < MAX_REGIONS;
    assign last_clear = scan_idx_reg == CNT_W'(MAX_REGIONS - 1);

    assign rep_cnt  = hit_rdata[HIT_W-1:HIT_COUNT_BITS];
    assign uni_cnt  = hit_rdata[HIT_COUNT_BITS-1:0];
    assign started  = move_rdata[MOVE_W-1];
    assign base_low = started ? move_rdata[COORD_W-1:0] : lo_reg;

    // first-match test against the entry read last cycle
    always_comb
    begin
        if (region_rdata.rep)
        begin
            match = chk_valid_reg && (region_rdata.r_begin <= lo_reg)
                    && (hi_reg <= region_rdata.r_end);
        end
        else
        begin
            match = chk_valid_reg && (region_rdata.r_begin < hi_reg)
                    && (lo_reg < region_rdata.r_end);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (last_clear)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (items.valid)
                begin
                    case (items.opcode)
                        OP_LOAD:  state_next = S_REPLY;
                        OP_BEGIN: state_next = S_BEGIN;
                        OP_PLACE: state_next = S_SCAN;
                        OP_END:   state_next = S_TALLY;
                        default:  state_next = S_REPLY;
                    endcase
                end
            end
            S_BEGIN:
            begin
                if (!scan_more)
                begin
                    state_next = S_REPLY;
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    state_next = S_UPDATE;
                end
                else if (scan_done)
                begin
                    state_next = S_REPLY;
                end
            end
            S_UPDATE:
            begin
                state_next = S_REPLY;
            end
            S_TALLY:
            begin
                if (scan_done)
                begin
                    state_next = S_REPLY;
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        scan_idx_next  = scan_idx_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        hit_idx_next   = hit_idx_reg;
        rpt_next       = rpt_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        used_next      = used_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_load       = 1'b0;
        items.ready    = state_reg == S_IDLE;

        region_we    = 1'b0;
        region_waddr = IDX_W'(items.slot);
        region_wdata = '{r_begin: items.coord_a, r_end: items.coord_b,
                         rep: items.repeat_region};
        region_re    = 1'b0;

        hit_we     = 1'b0;
        hit_waddr  = scan_idx_reg[IDX_W-1:0];
        hit_wdata  = '0;
        hit_re     = 1'b0;
        hit_raddr  = scan_idx_reg[IDX_W-1:0];

        move_we    = 1'b0;
        move_waddr = scan_idx_reg[IDX_W-1:0];
        move_wdata = '0;
        move_re    = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                hit_we        = 1'b1;
                move_we       = 1'b1;
                scan_idx_next = last_clear ? '0 : scan_idx_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    scan_idx_next  = '0;
                    chk_valid_next = 1'b0;
                    used_next      = '0;
                    lo_next        = (items.coord_a < items.coord_b) ? items.coord_a
                                                                    : items.coord_b;
                    hi_next        = (items.coord_a < items.coord_b) ? items.coord_b
                                                                    : items.coord_a;
                    res_next       = '0;
                    if (items.opcode == OP_LOAD)
                    begin
                        if (slot_ok)
                        begin
                            region_we = 1'b1;
                        end
                        else
                        begin
                            res_next.status = STAT_SLOT;
                        end
                    end
                end
            end
            S_BEGIN:
            begin
                if (scan_more)
                begin
                    hit_we        = !move_mode_reg;
                    move_we       = move_mode_reg;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                region_re      = scan_more;
                chk_valid_next = scan_more;
                chk_idx_next   = scan_idx_reg[IDX_W-1:0];
                if (scan_more)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                // tables read at the candidate so they are ready on a match
                hit_re    = chk_valid_reg;
                hit_raddr = chk_idx_reg;
                move_re   = chk_valid_reg;
                if (match)
                begin
                    hit_idx_next = chk_idx_reg;
                    rpt_next     = region_rdata.rep;
                end
                else if (scan_done)
                begin
                    res_next.status = STAT_NOMATCH;
                end
            end
            S_UPDATE:
            begin
                res_next.status         = STAT_OK;
                res_next.matched_region = SLOT_W'(hit_idx_reg);
                res_next.repeat_match   = rpt_reg;
                hit_waddr               = hit_idx_reg;
                move_waddr              = hit_idx_reg;
                if (move_mode_reg)
                begin
                    if (!started)
                    begin
                        move_we                  = 1'b1;
                        move_wdata               = {1'b1, lo_reg};
                        res_next.first_in_region = 1'b1;
                        res_next.repeat_heavy    = rep_cnt > uni_cnt;
                    end
                    res_next.shifted_start = signed'({1'b0, lo_reg} - {1'b0, base_low});
                    res_next.shifted_end   = signed'({1'b0, hi_reg} - {1'b0, base_low});
                end
                else
                begin
                    hit_we    = 1'b1;
                    hit_wdata = hit_rdata;
                    if (rpt_reg)
                    begin
                        if (rep_cnt != '1)
                        begin
                            hit_wdata[HIT_W-1:HIT_COUNT_BITS] = rep_cnt + 1'b1;
                        end
                    end
                    else
                    begin
                        if (uni_cnt != '1)
                        begin
                            hit_wdata[HIT_COUNT_BITS-1:0] = uni_cnt + 1'b1;
                        end
                    end
                end
            end
            S_TALLY:
            begin
                hit_re         = scan_more;
                chk_valid_next = scan_more;
                if (scan_more)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                if (chk_valid_reg && (hit_rdata != '0))
                begin
                    used_next = used_reg + 1'b1;
                end
                if (scan_done)
                begin
                    res_next.regions_used = USED_W'(used_reg);
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // region table
    always_ff @(posedge clk)
    begin
        if (region_we)
        begin
            region_mem[region_waddr] <= region_wdata;
        end
        if (region_re)
        begin
            region_rdata <= region_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    // hit tallies
    always_ff @(posedge clk)
    begin
        if (hit_we)
        begin
            hit_mem[hit_waddr] <= hit_wdata;
        end
        if (hit_re)
        begin
            hit_rdata <= hit_mem[hit_raddr];
        end
    end

    // started flag and low coordinate
    always_ff @(posedge clk)
    begin
        if (move_we)
        begin
            move_mem[move_waddr] <= move_wdata;
        end
        if (move_re)
        begin
            move_rdata <= move_mem[chk_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            scan_idx_reg     <= '0;
            chk_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            move_mode_reg    <= 1'b0;
            region_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MOVE_MODE:    move_mode_reg    <= cfg_wdata[0];
                    CFG_REGION_COUNT: region_count_reg <= cfg_wdata[RC_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        hit_idx_reg <= hit_idx_next;
        rpt_reg     <= rpt_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        used_reg    <= used_next;
        res_reg     <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.status          = out_reg.status;
    assign results.matched_region  = out_reg.matched_region;
    assign results.repeat_match    = out_reg.repeat_match;
    assign results.first_in_region = out_reg.first_in_region;
    assign results.repeat_heavy    = out_reg.repeat_heavy;
    assign results.shifted_start   = out_reg.shifted_start;
    assign results.shifted_end     = out_reg.shifted_end;
    assign results.regions_used    = out_reg.regions_used;

`ifndef SYNTHESIS
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_TALLY) |-> scan_idx_reg <= n_active)
        else $error("scan index ran past the active region count");

    a_update_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPDATE |-> $past(state_reg) == S_SCAN)
        else $error("update entered without a matching scan");

    a_heavy_first: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.repeat_heavy) |-> results.first_in_region)
        else $error("repeat_heavy reported off a first placement");

    a_first_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.first_in_region) |-> results.status == STAT_OK)
        else $error("first placement flagged on a failed operation");

    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.status == STAT_NOMATCH) |->
            (results.matched_region == '0 && results.shifted_start == '0
             && results.shifted_end == '0))
        else $error("miss result carries nonzero fields");
`endif

endmodule
